// ===== rtl/core/cs_pkg.sv =====
// ----------------------------------------------------------------------------
// cs_pkg: shared types and constants for the contrast stretch block
// Sample width, word formats of both channels, and divider control types.
// ----------------------------------------------------------------------------
package cs_pkg;

  // Sample width and derived sizes.
  localparam int PIXEL_BITS    = 8;
  localparam int DIVIDEND_BITS = 2 * PIXEL_BITS;
  localparam int CNT_BITS      = (PIXEL_BITS > 1) ? $clog2(PIXEL_BITS) : 1;

  typedef logic [PIXEL_BITS-1:0]    pixel_t;
  typedef logic [DIVIDEND_BITS-1:0] dividend_t;
  typedef logic [CNT_BITS-1:0]      count_t;

  localparam pixel_t PIX_MAX  = '1;
  localparam pixel_t PIX_ZERO = '0;
  localparam pixel_t PIX_ONE  = pixel_t'(1);

  // Opcodes of the input word.
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_MAP     = 1'b1;

  // Input word.
  typedef struct packed {
    logic   opcode;
    pixel_t pixel_in;
    logic   frame_last;
  } sample_t;

  // Output word.
  typedef struct packed {
    pixel_t pixel_out;
    logic   last_out;
  } result_t;

  // Divider sequencer states.
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  // Divider status seen by the top level.
  typedef struct packed {
    logic idle;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/core/cs_div.sv =====
// ----------------------------------------------------------------------------
// cs_div: bit-serial restoring divider
// Produces one quotient bit per cycle. The dividend's upper half must be
// below the divisor, so the quotient fits in one sample width.
// ----------------------------------------------------------------------------
module cs_div import cs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  dividend_t   dividend,
  input  pixel_t      divisor,
  input  logic        last_in,
  input  logic        take,
  output div_status_t status,
  output pixel_t      quotient,
  output logic        last
);

  div_state_t state, state_next;

  pixel_t     rem;
  pixel_t     num_low;
  pixel_t     dvsr;
  pixel_t     quo;
  count_t     cnt;
  logic       last_q;

  logic [PIXEL_BITS:0] trial;
  logic [PIXEL_BITS:0] diff;
  logic                fits;

  // One restoring step: bring down the next dividend bit and try to subtract.
  assign trial = {rem, num_low[PIXEL_BITS-1]};
  assign diff  = trial - {1'b0, dvsr};
  assign fits  = (trial >= {1'b0, dvsr});

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and status.
  always_comb begin
    state_next  = state;
    status.idle = 1'b0;
    status.done = 1'b0;
    unique case (state)
      DIV_IDLE: begin
        status.idle = 1'b1;
        if (start) begin
          state_next = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (cnt == '0) begin
          state_next = DIV_DONE;
        end
      end
      DIV_DONE: begin
        status.done = 1'b1;
        if (take) begin
          state_next = DIV_IDLE;
        end
      end
      default: begin
        state_next = DIV_IDLE;
      end
    endcase
  end

  // Datapath shift registers.
  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && start) begin
      rem     <= dividend[DIVIDEND_BITS-1:PIXEL_BITS];
      num_low <= dividend[PIXEL_BITS-1:0];
      dvsr    <= divisor;
      quo     <= PIX_ZERO;
      cnt     <= count_t'(PIXEL_BITS - 1);
      last_q  <= last_in;
    end else if (state == DIV_RUN) begin
      rem     <= fits ? diff[PIXEL_BITS-1:0] : trial[PIXEL_BITS-1:0];
      num_low <= {num_low[PIXEL_BITS-2:0], 1'b0};
      quo     <= {quo[PIXEL_BITS-2:0], fits};
      cnt     <= cnt - count_t'(1);
    end
  end

  assign quotient = quo;
  assign last     = last_q;

endmodule

// ===== rtl/core/contrast_stretch.sv =====
// ----------------------------------------------------------------------------
// contrast_stretch: min-max linear contrast stretch
// Tracks the sample range in a measure pass and rescales samples in a map pass.
// ----------------------------------------------------------------------------
// The image is sent twice. Measure words (opcode 0) update a running minimum
// and maximum and give no result; the measure word marked frame_last latches
// that pair and restarts the tracker. Map words (opcode 1) give one result
// each, floor(PIX_MAX * (p - min) / (max - min)), with 0 below the range and
// for a flat image, and PIX_MAX at or above the maximum. A map word runs
// through a bit-serial restoring divider that yields one quotient bit per
// cycle, and the input is stalled while the divider works. The result
// waits in an output register, so a stalled output holds the divider only
// once it has finished the next word.
module contrast_stretch import cs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_stall,
  input  sample_t sample,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  pixel_t running_min, running_max;
  pixel_t latched_min, latched_max;
  pixel_t min_next, max_next;

  logic        accept;
  logic        start;
  logic        take;
  dividend_t   dividend;
  pixel_t      divisor;
  pixel_t      offset;
  pixel_t      quotient;
  logic        div_last;
  div_status_t div_stat;

  // Input handshake: one word at a time through the divider.
  assign sample_stall = !div_stat.idle;
  assign accept       = sample_valid && !sample_stall;
  assign start        = accept && (sample.opcode == OP_MAP);

  // Running range of the measure pass.
  assign min_next = (sample.pixel_in < running_min) ? sample.pixel_in : running_min;
  assign max_next = (sample.pixel_in > running_max) ? sample.pixel_in : running_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_min <= PIX_MAX;
      running_max <= PIX_ZERO;
      latched_min <= PIX_ZERO;
      latched_max <= PIX_MAX;
    end else if (accept && sample.opcode == OP_MEASURE) begin
      if (sample.frame_last) begin
        latched_min <= min_next;
        latched_max <= max_next;
        running_min <= PIX_MAX;
        running_max <= PIX_ZERO;
      end else begin
        running_min <= min_next;
        running_max <= max_next;
      end
    end
  end

  // Divider operands. Clamped cases divide a fixed value by one.
  assign offset = sample.pixel_in - latched_min;

  always_comb begin
    priority if (latched_max <= latched_min || sample.pixel_in <= latched_min) begin
      dividend = '0;
      divisor  = PIX_ONE;
    end else if (sample.pixel_in >= latched_max) begin
      dividend = {PIX_ZERO, PIX_MAX};
      divisor  = PIX_ONE;
    end else begin
      // PIX_MAX * offset, written as offset shifted up minus offset.
      dividend = {offset, PIX_ZERO} - {PIX_ZERO, offset};
      divisor  = latched_max - latched_min;
    end
  end

  cs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (dividend),
    .divisor  (divisor),
    .last_in  (sample.frame_last),
    .take     (take),
    .status   (div_stat),
    .quotient (quotient),
    .last     (div_last)
  );

  // Output register: loads a finished quotient when empty or being drained.
  assign take = div_stat.done && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.pixel_out <= quotient;
      result.last_out  <= div_last;
    end
  end

endmodule
